// ----- src/cgd_pkg.sv -----
// package: field widths, calendar tables and division constants for the calendar grid resolver
package cgd_pkg;

  localparam int unsigned RowW   = 3;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CmonW  = 5;
  localparam int unsigned AyW    = 15;
  localparam int unsigned CentW  = 8;
  localparam int unsigned Q25W   = 10;
  localparam int unsigned YrCW   = 7;
  localparam int unsigned SumW   = 10;
  localparam int unsigned RawW   = 6;

  localparam logic [MonW-1:0]  LastMonth  = 4'd11;
  localparam logic [MonW-1:0]  February   = 4'd1;
  localparam logic [AyW-1:0]   YearOffset = 15'd400;

  // floor division by reciprocal multiply, exact over the value ranges used
  localparam logic [14:0] Recip100 = 15'd20972;
  localparam int unsigned Shift100 = 21;
  localparam logic [14:0] Recip25  = 15'd20972;
  localparam int unsigned Shift25  = 19;
  localparam logic [13:0] Recip7   = 14'd9363;
  localparam int unsigned Shift7   = 16;

  // constant 1 of the congruence, +5 for the monday base, +7*48 to stay positive
  localparam logic [SumW:0] SumBias = 11'd342;

  typedef logic [5:0] mterm_t;
  typedef logic [DayW-1:0] mlen_t;

  // floor(13*(zm+1)/5) for each month, january and february as months 13 and 14
  localparam mterm_t MonthTerm [12] = '{
    6'd36, 6'd39, 6'd10, 6'd13, 6'd15, 6'd18,
    6'd20, 6'd23, 6'd26, 6'd28, 6'd31, 6'd33
  };

  localparam mlen_t MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic mlen_t month_days(input logic [MonW-1:0] m, input logic leap);
    mlen_t base;
    base = MonthLen[m];
    if (m == February && leap) begin
      base = base + 5'd1;
    end
    return base;
  endfunction

endpackage

// ----- src/cgd_in_if.sv -----
// interface: cell query channel
interface cgd_in_if;
  import cgd_pkg::*;

  logic              valid;
  logic              ready;
  logic [RowW-1:0]   week_row;
  logic [WdayW-1:0]  weekday;
  logic [MonW-1:0]   month;
  logic [YearW-1:0]  year;

  modport source (output valid, output week_row, output weekday, output month,
                  output year, input ready);
  modport sink   (input valid, input week_row, input weekday, input month,
                  input year, output ready);
endinterface

// ----- src/cgd_out_if.sv -----
// interface: resolved cell channel
interface cgd_out_if;
  import cgd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DayW-1:0]         day;
  logic signed [CmonW-1:0] cell_month;

  modport source (output valid, output day, output cell_month, input ready);
  modport sink   (input valid, input day, input cell_month, output ready);
endinterface

// ----- src/calendar_grid_day_of_month_top.sv -----
// top level: seven-stage pipeline resolving a month-grid cell to day and month
// One cell query is taken per clock while no stall backs up to the input,
// and each gives exactly one result. Throughput is one transaction per cycle,
// limited only by the output side: every stage holds its own valid bit and
// takes a new transaction whenever it is empty or its successor moves on,
// so a stalled result never blocks filling of empty stages behind it. The
// stages are: year offset, century and year/25 quotients by reciprocal
// multiply, year-of-century and leap flag, congruence sum, modulo 7 for the
// weekday of the 1st, grid arithmetic and month lengths, final selection.
// Months above 11 are treated as December. cell_month is -1 for December of
// the prior year and 12 for January of the next year.
module calendar_grid_day_of_month_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cgd_in_if.sink     cell_i,
  cgd_out_if.source  result_o
);
  import cgd_pkg::*;

  localparam int unsigned NStage = 7;

  logic [NStage-1:0] vld_q;
  logic [NStage-1:0] adv;

  // stage 1
  logic [RowW-1:0]  row1_q;
  logic [WdayW-1:0] wd1_q;
  logic [MonW-1:0]  m1_q;
  logic [AyW-1:0]   ay1_q;
  logic [YearW-1:0] y1_q;
  // stage 2
  logic [RowW-1:0]  row2_q;
  logic [WdayW-1:0] wd2_q;
  logic [MonW-1:0]  m2_q;
  logic [AyW-1:0]   ay2_q;
  logic [YearW-1:0] y2_q;
  logic [CentW-1:0] j2_q;
  logic [Q25W-1:0]  q25_2_q;
  // stage 3
  logic [RowW-1:0]  row3_q;
  logic [WdayW-1:0] wd3_q;
  logic [MonW-1:0]  m3_q;
  logic [YrCW-1:0]  k3_q;
  logic [CentW-1:0] j3_q;
  logic             leap3_q;
  // stage 4
  logic [RowW-1:0]  row4_q;
  logic [WdayW-1:0] wd4_q;
  logic [MonW-1:0]  m4_q;
  logic             leap4_q;
  logic [SumW-1:0]  s4_q;
  // stage 5
  logic [RowW-1:0]  row5_q;
  logic [WdayW-1:0] wd5_q;
  logic [MonW-1:0]  m5_q;
  logic             leap5_q;
  logic [2:0]       first5_q;
  // stage 6
  logic [MonW-1:0]  m6_q;
  logic             under6_q;
  logic             nz6_q;
  logic [DayW-1:0]  prev_day6_q;
  logic [RawW-1:0]  raw6_q;
  logic [DayW-1:0]  cur_len6_q;
  // stage 7
  logic [DayW-1:0]         day7_q;
  logic signed [CmonW-1:0] cm7_q;

  logic [MonW-1:0]   m_sat;
  logic [AyW-1:0]    ay_d;
  logic [29:0]       cent_prod;
  logic [28:0]       q25_prod;
  logic [AyW-1:0]    k_full;
  logic [YearW-1:0]  r25;
  logic              leap_d;
  logic [SumW:0]     sum_d;
  logic [23:0]       q7_prod;
  logic [SumW-1:0]   r7;
  logic [MonW-1:0]   prev_m;
  logic [DayW-1:0]   prev_len;
  logic [RawW:0]     raw_d;
  logic [DayW-1:0]   prev_day_d;
  logic [RawW-1:0]   ovf_day;
  logic [DayW-1:0]   day_d;
  logic signed [CmonW-1:0] cm_d;

  // per-stage advance, evaluated from the output back
  always_comb begin
    adv[NStage-1] = !vld_q[NStage-1] || result_o.ready;
    for (int i = NStage - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign cell_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= cell_i.valid;
      end
      for (int i = 1; i < NStage; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stage 1: month saturation and year offset for the congruence
  always_comb begin
    m_sat = (cell_i.month > LastMonth) ? LastMonth : cell_i.month;
    ay_d  = AyW'(cell_i.year) + YearOffset;
    if (m_sat < 4'd2) begin
      ay_d = ay_d - AyW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      row1_q <= cell_i.week_row;
      wd1_q  <= cell_i.weekday;
      m1_q   <= m_sat;
      ay1_q  <= ay_d;
      y1_q   <= cell_i.year;
    end
  end

  // stage 2: century and year/25 quotients
  assign cent_prod = 30'(ay1_q) * 30'(Recip100);
  assign q25_prod  = 29'(y1_q) * 29'(Recip25);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      row2_q  <= row1_q;
      wd2_q   <= wd1_q;
      m2_q    <= m1_q;
      ay2_q   <= ay1_q;
      y2_q    <= y1_q;
      j2_q    <= CentW'(cent_prod >> Shift100);
      q25_2_q <= Q25W'(q25_prod >> Shift25);
    end
  end

  // stage 3: year of century and leap flag
  assign k_full = ay2_q - AyW'(j2_q) * AyW'(100);
  assign r25    = y2_q - YearW'(q25_2_q) * YearW'(25);
  assign leap_d = (y2_q[1:0] == 2'd0) && ((r25 != '0) || (y2_q[3:0] == 4'd0));

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      row3_q  <= row2_q;
      wd3_q   <= wd2_q;
      m3_q    <= m2_q;
      k3_q    <= YrCW'(k_full);
      j3_q    <= j2_q;
      leap3_q <= leap_d;
    end
  end

  // stage 4: congruence sum
  assign sum_d = SumBias + (SumW+1)'(MonthTerm[m3_q]) + (SumW+1)'(k3_q)
               + (SumW+1)'(k3_q >> 2) + (SumW+1)'(j3_q >> 2)
               - ((SumW+1)'(j3_q) << 1);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      row4_q  <= row3_q;
      wd4_q   <= wd3_q;
      m4_q    <= m3_q;
      leap4_q <= leap3_q;
      s4_q    <= SumW'(sum_d);
    end
  end

  // stage 5: modulo 7 gives the weekday of the 1st
  assign q7_prod = 24'(s4_q) * 24'(Recip7);
  assign r7      = s4_q - SumW'(q7_prod >> Shift7) * SumW'(7);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      row5_q   <= row4_q;
      wd5_q    <= wd4_q;
      m5_q     <= m4_q;
      leap5_q  <= leap4_q;
      first5_q <= r7[2:0];
    end
  end

  // stage 6: grid position and month lengths
  always_comb begin
    prev_m     = (m5_q == '0) ? LastMonth : m5_q - MonW'(1);
    prev_len   = month_days(prev_m, leap5_q);
    raw_d      = (RawW+1)'(row5_q) * (RawW+1)'(7) + (RawW+1)'(wd5_q)
               + (RawW+1)'(1) - (RawW+1)'(first5_q);
    prev_day_d = prev_len - DayW'(first5_q) + DayW'(wd5_q) + DayW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      m6_q        <= m5_q;
      under6_q    <= (row5_q == '0) && (wd5_q < first5_q);
      nz6_q       <= (row5_q != '0);
      prev_day6_q <= prev_day_d;
      raw6_q      <= RawW'(raw_d);
      cur_len6_q  <= month_days(m5_q, leap5_q);
    end
  end

  // stage 7: choose previous, shown or next month
  assign ovf_day = raw6_q - RawW'(cur_len6_q);

  always_comb begin
    if (under6_q) begin
      day_d = prev_day6_q;
      cm_d  = CmonW'(m6_q) - CmonW'(1);
    end else if (nz6_q && (raw6_q > RawW'(cur_len6_q))) begin
      day_d = DayW'(ovf_day);
      cm_d  = CmonW'(m6_q) + CmonW'(1);
    end else begin
      day_d = DayW'(raw6_q);
      cm_d  = CmonW'(m6_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      day7_q <= day_d;
      cm7_q  <= cm_d;
    end
  end

  assign result_o.valid      = vld_q[NStage-1];
  assign result_o.day        = day7_q;
  assign result_o.cell_month = cm7_q;

endmodule

// ----- sim/tb_cgd_checker.sv -----
// checker: predicts the resolved day and month of each cell query and compares the results
module tb_cgd_checker
  import cgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cgd_in_if           cell_i,
  cgd_out_if          result_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MonFeb = 1;
  localparam int MonDec = 11;
  localparam int MonsPerYear = 12;
  localparam int DaysPerWeek = 7;

  typedef struct packed {
    logic [DayW-1:0]         day;
    logic signed [CmonW-1:0] cell_month;
  } cell_res_t;

  cell_res_t   resolved_q [$];
  cell_res_t   want;
  int unsigned errs = 0;

  function automatic int month_span(input int m, input int leap);
    int idx;
    idx = ((m % MonsPerYear) + MonsPerYear) % MonsPerYear;
    case (idx)
      MonFeb:        return 28 + leap;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic cell_res_t resolve_cell(input logic [RowW-1:0] row_in,
                                             input logic [WdayW-1:0] wd_in,
                                             input logic [MonW-1:0] mon_in,
                                             input logic [YearW-1:0] yr_in);
    int r, w, m, y, leap, zm, ay, k, j, s, first, d;
    cell_res_t res;
    r = row_in;
    w = wd_in;
    m = mon_in;
    y = yr_in;
    if (m > MonDec) m = MonDec;
    leap = ((y % 4) == 0 && ((y % 100) != 0 || (y % 400) == 0)) ? 1 : 0;
    // zeller with january and february as months 13 and 14 of the prior year
    zm = (m < 2) ? m + 13 : m + 1;
    ay = ((m >= 2) ? y : y - 1) + 400;
    k = ay % 100;
    j = ay / 100;
    s = 1 + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 - 2 * j;
    first = ((((s % DaysPerWeek) + DaysPerWeek) % DaysPerWeek) + 5) % DaysPerWeek;
    if (r == 0 && w < first) begin
      d = month_span(m - 1, leap) - (first - w - 1);
      m = m - 1;
    end else begin
      d = DaysPerWeek * r + w - first + 1;
    end
    if (r != 0 && d > month_span(m, leap)) begin
      d = d - month_span(m, leap);
      m = m + 1;
    end
    res.day        = d[DayW-1:0];
    res.cell_month = m[CmonW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_i.valid && result_i.ready) begin
        if (resolved_q.size() == 0) begin
          $display("%0t: unexpected transaction day %0d cell_month %0d", $time,
                   result_i.day, result_i.cell_month);
          errs++;
        end else begin
          want = resolved_q.pop_front();
          if (result_i.day !== want.day) begin
            $display("%0t: day mismatch expected %0d actual %0d", $time,
                     want.day, result_i.day);
            errs++;
          end
          if (result_i.cell_month !== want.cell_month) begin
            $display("%0t: cell_month mismatch expected %0d actual %0d", $time,
                     want.cell_month, result_i.cell_month);
            errs++;
          end
        end
      end
      if (cell_i.valid && cell_i.ready) begin
        resolved_q.push_back(resolve_cell(cell_i.week_row, cell_i.weekday,
                                          cell_i.month, cell_i.year));
      end
    end
    mismatches_o <= errs;
    pending_o    <= resolved_q.size();
  end

endmodule

// ----- sim/tb_calendar_grid_day_of_month_top.sv -----
// testbench top: clock, reset, cell query stimulus, result back-pressure and verdict
module tb_calendar_grid_day_of_month_top;
  import cgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandCells  = 900;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned HoldAt     = 200;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned CalmFrom   = 350;
  localparam int unsigned CalmTo     = 550;
  localparam int unsigned IdlePct    = 17;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent_n = 0;
  int unsigned cyc = 0;

  cgd_in_if  cell_ch ();
  cgd_out_if result ();

  calendar_grid_day_of_month_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (cell_ch),
    .result_o (result)
  );

  tb_cgd_checker resolve_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_i       (cell_ch),
    .result_i     (result),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic push_cell(input logic [RowW-1:0] r, input logic [WdayW-1:0] w,
                           input logic [MonW-1:0] m, input logic [YearW-1:0] y);
    while ((sent_n < CalmFrom || sent_n > CalmTo) && $urandom_range(99) < IdlePct) begin
      cell_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_ch.valid    <= 1'b1;
    cell_ch.week_row <= r;
    cell_ch.weekday  <= w;
    cell_ch.month    <= m;
    cell_ch.year     <= y;
    do @(posedge clk_i); while (!cell_ch.ready);
    sent_n++;
  endtask

  // result side: random stalls, one long hold-off, a calm stretch
  initial begin : drain
    int unsigned seen;
    int unsigned hold;
    bit          held;
    seen = 0;
    hold = 0;
    held = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cell_ch.valid && cell_ch.ready) seen++;
      if (!held && seen >= HoldAt) begin
        held = 1'b1;
        hold = HoldLen;
      end
      if (hold != 0) begin
        hold--;
        result.ready <= 1'b0;
      end else if (seen >= CalmFrom && seen <= CalmTo) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : watchdog
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("calendar_grid_day_of_month_top test failed");
    $finish;
  end

  initial begin : stim
    rst_ni           <= 1'b0;
    cell_ch.valid    <= 1'b0;
    cell_ch.week_row <= '0;
    cell_ch.weekday  <= '0;
    cell_ch.month    <= '0;
    cell_ch.year     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells: field extremes, year zero, leap februaries, wrap months
    push_cell(3'd0, 3'd0, 4'd0,  14'd1);
    push_cell(3'd0, 3'd0, 4'd0,  14'd0);
    push_cell(3'd5, 3'd6, 4'd1,  14'd0);
    push_cell(3'd0, 3'd0, 4'd0,  14'd2024);
    push_cell(3'd4, 3'd6, 4'd1,  14'd2024);
    push_cell(3'd4, 3'd6, 4'd1,  14'd2023);
    push_cell(3'd4, 3'd6, 4'd1,  14'd1900);
    push_cell(3'd4, 3'd6, 4'd1,  14'd2000);
    push_cell(3'd5, 3'd6, 4'd11, 14'd9999);
    push_cell(3'd0, 3'd0, 4'd11, 14'd9999);
    push_cell(3'd0, 3'd0, 4'd0,  14'd16383);
    push_cell(3'd7, 3'd7, 4'd15, 14'd16383);
    push_cell(3'd6, 3'd3, 4'd12, 14'd2021);
    push_cell(3'd6, 3'd0, 4'd13, 14'd1);
    push_cell(3'd0, 3'd7, 4'd3,  14'd1999);
    push_cell(3'd7, 3'd0, 4'd6,  14'd1582);
    push_cell(3'd6, 3'd7, 4'd8,  14'd400);
    push_cell(3'd3, 3'd4, 4'd9,  14'd100);
    push_cell(3'd0, 3'd6, 4'd2,  14'd1);
    push_cell(3'd1, 3'd0, 4'd4,  14'd8191);
    push_cell(3'd2, 3'd5, 4'd10, 14'd4096);
    push_cell(3'd0, 3'd3, 4'd14, 14'd2);

    // mostly calendar-shaped cells, the rest raw field values
    repeat (RandCells) begin
      if ($urandom_range(99) < 80) begin
        push_cell(RowW'($urandom_range(5)), WdayW'($urandom_range(6)),
                  MonW'($urandom_range(11)), YearW'($urandom_range(9999, 1)));
      end else begin
        push_cell(RowW'($urandom_range(7)), WdayW'($urandom_range(7)),
                  MonW'($urandom_range(15)), YearW'($urandom_range(16383)));
      end
    end
    cell_ch.valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("calendar_grid_day_of_month_top test passed");
    end else begin
      $display("calendar_grid_day_of_month_top test failed");
    end
    $finish;
  end

endmodule
